@@ rtl/core/mtrl_pkg.sv @@
// shared constants, types and address helpers for the multibit trie route table
`timescale 1ns / 1ps
package mtrl_pkg;

  localparam int ROUTE_SLOTS   = 1024;
  localparam int NODE_POOL     = 4096;
  localparam int ROOT_FANOUT   = 256;
  localparam int NODE_FANOUT   = 16;
  localparam int SLOT_W        = $clog2(ROUTE_SLOTS);
  localparam int KEY_W         = SLOT_W + 1;
  localparam int NODE_W        = $clog2(NODE_POOL) + 1;
  localparam int HEAP_W        = $clog2(2 * ROOT_FANOUT);
  localparam int ROOT_KEY_SPAN = 2 * ROOT_FANOUT;
  localparam int NODE_KEY_SPAN = 2 * NODE_FANOUT;
  localparam int KEY_DEPTH     = ROOT_KEY_SPAN + NODE_POOL * NODE_KEY_SPAN;
  localparam int LINK_DEPTH    = ROOT_FANOUT + NODE_POOL * NODE_FANOUT;
  localparam int KADDR_W       = $clog2(KEY_DEPTH);
  localparam int LADDR_W       = $clog2(LINK_DEPTH);
  localparam int ROUTE_W       = 40;

  // request codes
  localparam logic [1:0] OP_LOOKUP = 2'd0;
  localparam logic [1:0] OP_ADD    = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;

  // result codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_EXISTS = 2'd1;
  localparam logic [1:0] ST_MISS   = 2'd2;
  localparam logic [1:0] ST_FULL   = 2'd3;

  typedef struct packed {
    logic               rd_en;
    logic [KADDR_W-1:0] rd_addr;
    logic               wr_en;
    logic [KADDR_W-1:0] wr_addr;
    logic [KEY_W-1:0]   wr_data;
  } key_req_t;

  typedef struct packed {
    logic               rd_en;
    logic [LADDR_W-1:0] rd_addr;
    logic               wr_en;
    logic [LADDR_W-1:0] wr_addr;
    logic [NODE_W-1:0]  wr_data;
  } link_req_t;

  typedef struct packed {
    logic               rt_rd_en;
    logic [SLOT_W-1:0]  rt_rd_addr;
    logic               rt_wr_en;
    logic [SLOT_W-1:0]  rt_wr_addr;
    logic [ROUTE_W-1:0] rt_wr_data;
    logic               fl_rd_en;
    logic [SLOT_W-1:0]  fl_rd_addr;
    logic               fl_wr_en;
    logic [SLOT_W-1:0]  fl_wr_addr;
    logic [KEY_W-1:0]   fl_wr_data;
  } slot_req_t;

  // heap key address: root occupies the first span, pool node k-1 follows
  function automatic logic [KADDR_W-1:0] key_addr(logic [NODE_W-1:0] node,
                                                  logic [HEAP_W-1:0] h);
    logic [KADDR_W-1:0] a;
    if (node == '0) begin
      a = KADDR_W'(h);
    end else begin
      a = KADDR_W'(ROOT_KEY_SPAN)
        + (KADDR_W'(node - NODE_W'(1)) << $clog2(NODE_KEY_SPAN))
        + KADDR_W'(h[$clog2(NODE_KEY_SPAN)-1:0]);
    end
    return a;
  endfunction

  function automatic logic [LADDR_W-1:0] link_addr(logic [NODE_W-1:0] node,
                                                   logic [7:0] idx);
    logic [LADDR_W-1:0] a;
    if (node == '0) begin
      a = LADDR_W'(idx);
    end else begin
      a = LADDR_W'(ROOT_FANOUT)
        + (LADDR_W'(node - NODE_W'(1)) << $clog2(NODE_FANOUT))
        + LADDR_W'(idx[3:0]);
    end
    return a;
  endfunction

  // address bits that index the node at a trie level
  function automatic logic [7:0] level_idx(logic [31:0] addr, logic [2:0] lvl);
    logic [7:0] r;
    unique case (lvl)
      3'd0:    r = addr[31:24];
      3'd1:    r = {4'd0, addr[23:20]};
      3'd2:    r = {4'd0, addr[19:16]};
      3'd3:    r = {4'd0, addr[15:12]};
      3'd4:    r = {4'd0, addr[11:8]};
      3'd5:    r = {4'd0, addr[7:4]};
      default: r = {4'd0, addr[3:0]};
    endcase
    return r;
  endfunction

  // leaf heap index fanout + idx
  function automatic logic [HEAP_W-1:0] leaf_heap(logic [NODE_W-1:0] node,
                                                  logic [7:0] idx);
    logic [HEAP_W-1:0] h;
    if (node == '0) h = {1'b1, idx};
    else            h = HEAP_W'({1'b1, idx[3:0]});
    return h;
  endfunction

endpackage

@@ rtl/core/mtrl_trie_mem.sv @@
// trie key and child link memories with the post-reset clearing pass
`timescale 1ns / 1ps
module mtrl_trie_mem (
  input  logic                          clk,
  input  logic                          rst_n,
  input  mtrl_pkg::key_req_t            key_req,
  input  mtrl_pkg::link_req_t           link_req,
  output logic [mtrl_pkg::KEY_W-1:0]    key_rdata,
  output logic [mtrl_pkg::NODE_W-1:0]   link_rdata,
  output logic                          clr_busy
);

  logic [mtrl_pkg::KEY_W-1:0]  key_mem  [mtrl_pkg::KEY_DEPTH];
  logic [mtrl_pkg::NODE_W-1:0] link_mem [mtrl_pkg::LINK_DEPTH];

  logic [mtrl_pkg::KADDR_W-1:0] clr_r, clr_nxt;
  logic                         busy_r, busy_nxt;
  logic [mtrl_pkg::KEY_W-1:0]   key_rd_r;
  logic [mtrl_pkg::NODE_W-1:0]  link_rd_r;

  logic                         kwe, lwe;
  logic [mtrl_pkg::KADDR_W-1:0] kwa;
  logic [mtrl_pkg::LADDR_W-1:0] lwa;
  logic [mtrl_pkg::KEY_W-1:0]   kwd;
  logic [mtrl_pkg::NODE_W-1:0]  lwd;

  always_comb begin
    clr_nxt  = clr_r;
    busy_nxt = busy_r;
    if (busy_r) begin
      clr_nxt = clr_r + mtrl_pkg::KADDR_W'(1);
      if (clr_r == mtrl_pkg::KADDR_W'(mtrl_pkg::KEY_DEPTH - 1)) busy_nxt = 1'b0;
    end
  end

  always_comb begin
    if (busy_r) begin
      kwe = 1'b1;
      kwa = clr_r;
      kwd = '0;
      lwe = (clr_r < mtrl_pkg::KADDR_W'(mtrl_pkg::LINK_DEPTH));
      lwa = clr_r[mtrl_pkg::LADDR_W-1:0];
      lwd = '0;
    end else begin
      kwe = key_req.wr_en;
      kwa = key_req.wr_addr;
      kwd = key_req.wr_data;
      lwe = link_req.wr_en;
      lwa = link_req.wr_addr;
      lwd = link_req.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r  <= '0;
      busy_r <= 1'b1;
    end else begin
      clr_r  <= clr_nxt;
      busy_r <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (kwe) key_mem[kwa] <= kwd;
    if (key_req.rd_en) key_rd_r <= key_mem[key_req.rd_addr];
  end

  always_ff @(posedge clk) begin
    if (lwe) link_mem[lwa] <= lwd;
    if (link_req.rd_en) link_rd_r <= link_mem[link_req.rd_addr];
  end

  assign key_rdata  = key_rd_r;
  assign link_rdata = link_rd_r;
  assign clr_busy   = busy_r;

endmodule

@@ rtl/core/mtrl_slot_mem.sv @@
// route slot store and free slot link memory
`timescale 1ns / 1ps
module mtrl_slot_mem (
  input  logic                          clk,
  input  mtrl_pkg::slot_req_t           req,
  output logic [mtrl_pkg::ROUTE_W-1:0]  route_rdata,
  output logic [mtrl_pkg::KEY_W-1:0]    free_rdata
);

  logic [mtrl_pkg::ROUTE_W-1:0] route_mem [mtrl_pkg::ROUTE_SLOTS];
  logic [mtrl_pkg::KEY_W-1:0]   free_mem  [mtrl_pkg::ROUTE_SLOTS];
  logic [mtrl_pkg::ROUTE_W-1:0] route_rd_r;
  logic [mtrl_pkg::KEY_W-1:0]   free_rd_r;

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (req.rt_wr_en) route_mem[req.rt_wr_addr] <= req.rt_wr_data;
    if (req.rt_rd_en) route_rd_r <= route_mem[req.rt_rd_addr];
  end

  always_ff @(posedge clk) begin
    if (req.fl_wr_en) free_mem[req.fl_wr_addr] <= req.fl_wr_data;
    if (req.fl_rd_en) free_rd_r <= free_mem[req.fl_rd_addr];
  end

  assign route_rdata = route_rd_r;
  assign free_rdata  = free_rd_r;

endmodule

@@ rtl/core/multibit_trie_route_lookup_top.sv @@
// top level: request sequencer of the multibit trie route table
//
// channel  dir  beat contents
// in_*     in   tuser opcode; tdata address, prefix_length, gateway, out_port, replace
// out_*    out  tuser status, had_route; tdata result_gateway, result_port
//
// one request at a time; every memory read is registered before it is used
// lookup: reads the key and link of each trie level visited (1 to 7 levels), then the route slot
// add/remove: walk the levels, read the heap entry and its parent, then sweep each heap
//   entry of the expanded subtree (up to 255 in the root, 15 in a node)
// default route add/remove skips the trie; add with no slot left or unknown opcode goes straight to the result
// after reset the trie memories are cleared one entry a cycle, all 131584 key entries, with in_tready low
// a finished result waits in the output register; the next request is taken meanwhile
`timescale 1ns / 1ps
module multibit_trie_route_lookup_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [79:0] in_tdata,   // address[31:0], prefix_length[37:32], gateway[69:38],
                                  // out_port[77:70], replace[78], zero pad
  input  logic [1:0]  in_tuser,   // opcode[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // result_gateway[31:0], result_port[39:32]
  output logic [2:0]  out_tuser   // status[1:0], had_route[2]
);

  localparam int KEY_W  = mtrl_pkg::KEY_W;
  localparam int NODE_W = mtrl_pkg::NODE_W;
  localparam int SLOT_W = mtrl_pkg::SLOT_W;
  localparam int HEAP_W = mtrl_pkg::HEAP_W;

  typedef enum logic [13:0] {
    S_IDLE    = 14'b00000000000001,
    S_LK_RD   = 14'b00000000000010,
    S_LK_EV   = 14'b00000000000100,
    S_POP     = 14'b00000000001000,
    S_ADD_WR  = 14'b00000000010000,
    S_WK      = 14'b00000000100000,
    S_WK_LINK = 14'b00000001000000,
    S_H_RD    = 14'b00000010000000,
    S_H_PAR   = 14'b00000100000000,
    S_SW      = 14'b00001000000000,
    S_FIN     = 14'b00010000000000,
    S_RT_RD   = 14'b00100000000000,
    S_OUT     = 14'b01000000000000,
    S_SPARE   = 14'b10000000000000
  } state_t;

  state_t state_r, state_nxt;

  // request fields
  logic [1:0]  op_r, op_nxt;
  logic [31:0] addr_r, addr_nxt;
  logic [5:0]  len_r, len_nxt;
  logic [31:0] gw_r, gw_nxt;
  logic [7:0]  port_r, port_nxt;
  logic        rep_r, rep_nxt;

  // walk and sweep
  logic [NODE_W-1:0] node_r, node_nxt;
  logic [2:0]        lvl_r, lvl_nxt;
  logic [KEY_W-1:0]  cur_r, cur_nxt;     // best key on lookup, previous key on update
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic [HEAP_W-1:0] h_r, h_nxt;
  logic [KEY_W-1:0]  old_r, old_nxt;
  logic [KEY_W-1:0]  nk_r, nk_nxt;
  logic [9:0]        base_r, base_nxt;
  logic [9:0]        w_r, w_nxt;
  logic [9:0]        off_r, off_nxt;
  logic              pend_r, pend_nxt;
  logic [HEAP_W-1:0] wx_r, wx_nxt;

  // result and free list action
  logic [1:0]        res_st_r, res_st_nxt;
  logic [KEY_W-1:0]  res_key_r, res_key_nxt;
  logic              free_en_r, free_en_nxt;
  logic [SLOT_W-1:0] free_slot_r, free_slot_nxt;

  // table bookkeeping
  logic [NODE_W-1:0] nodes_used_r, nodes_used_nxt;
  logic [KEY_W-1:0]  default_r, default_nxt;
  logic [KEY_W-1:0]  head_r, head_nxt;
  logic [KEY_W-1:0]  used_r, used_nxt;

  // output register
  logic        out_valid_r, out_valid_nxt;
  logic [1:0]  out_st_r, out_st_nxt;
  logic        out_had_r, out_had_nxt;
  logic [31:0] out_gw_r, out_gw_nxt;
  logic [7:0]  out_port_r, out_port_nxt;

  mtrl_pkg::key_req_t  key_req;
  mtrl_pkg::link_req_t link_req;
  mtrl_pkg::slot_req_t slot_req;
  logic [KEY_W-1:0]             key_rdata;
  logic [NODE_W-1:0]            link_rdata;
  logic [mtrl_pkg::ROUTE_W-1:0] route_rdata;
  logic [KEY_W-1:0]             free_rdata;
  logic                         clr_busy;

  mtrl_trie_mem u_trie (
    .clk        (clk),
    .rst_n      (rst_n),
    .key_req    (key_req),
    .link_req   (link_req),
    .key_rdata  (key_rdata),
    .link_rdata (link_rdata),
    .clr_busy   (clr_busy)
  );

  mtrl_slot_mem u_slot (
    .clk         (clk),
    .req         (slot_req),
    .route_rdata (route_rdata),
    .free_rdata  (free_rdata)
  );

  logic             accept;
  logic [5:0]       in_len;
  logic [7:0]       idx;
  logic [HEAP_W-1:0] leaf;
  logic [6:0]       thr;
  logic [6:0]       sh;
  logic             descend;
  logic             hgt3;
  logic [KEY_W-1:0] prev, nk;
  logic             set_ok;
  logic [9:0]       span;
  logic [HEAP_W-1:0] sw_x;
  logic [NODE_W-1:0] new_node;
  logic             key_ok;

  assign in_tready = (state_r == S_IDLE) && !clr_busy;
  assign accept    = in_tvalid && in_tready;
  assign in_len    = (in_tdata[37:32] > 6'd32) ? 6'd32 : in_tdata[37:32];

  // level geometry: prefix ends here unless it reaches below the level's bits
  assign idx      = mtrl_pkg::level_idx(addr_r, lvl_r);
  assign leaf     = mtrl_pkg::leaf_heap(node_r, idx);
  assign thr      = 7'd8 + {2'd0, lvl_r, 2'd0};
  assign descend  = (lvl_r <= 3'd5) && ({1'b0, len_r} > thr);
  assign sh       = thr - {1'b0, len_r};
  assign hgt3     = h_r > HEAP_W'(3);
  assign span     = (node_r == '0) ? 10'(mtrl_pkg::ROOT_KEY_SPAN)
                                   : 10'(mtrl_pkg::NODE_KEY_SPAN);
  assign sw_x     = HEAP_W'(base_r + off_r);
  assign new_node = nodes_used_r + NODE_W'(1);
  assign key_ok   = (res_key_r != '0) && (res_key_r <= KEY_W'(mtrl_pkg::ROUTE_SLOTS));

  // previous key and replacement key of the expanded prefix
  always_comb begin
    prev = old_r;
    if (old_r != '0 && hgt3 && key_rdata == old_r) prev = '0;
    if (op_r == mtrl_pkg::OP_ADD) begin
      nk     = {1'b0, slot_r} + KEY_W'(1);
      set_ok = rep_r;
    end else begin
      nk     = hgt3 ? key_rdata : '0;
      set_ok = 1'b1;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    addr_nxt       = addr_r;
    len_nxt        = len_r;
    gw_nxt         = gw_r;
    port_nxt       = port_r;
    rep_nxt        = rep_r;
    node_nxt       = node_r;
    lvl_nxt        = lvl_r;
    cur_nxt        = cur_r;
    slot_nxt       = slot_r;
    h_nxt          = h_r;
    old_nxt        = old_r;
    nk_nxt         = nk_r;
    base_nxt       = base_r;
    w_nxt          = w_r;
    off_nxt        = off_r;
    pend_nxt       = pend_r;
    wx_nxt         = wx_r;
    res_st_nxt     = res_st_r;
    res_key_nxt    = res_key_r;
    free_en_nxt    = free_en_r;
    free_slot_nxt  = free_slot_r;
    nodes_used_nxt = nodes_used_r;
    default_nxt    = default_r;
    head_nxt       = head_r;
    used_nxt       = used_r;
    out_valid_nxt  = out_tready ? 1'b0 : out_valid_r;
    out_st_nxt     = out_st_r;
    out_had_nxt    = out_had_r;
    out_gw_nxt     = out_gw_r;
    out_port_nxt   = out_port_r;
    key_req        = '0;
    link_req       = '0;
    slot_req       = '0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          op_nxt      = in_tuser;
          addr_nxt    = in_tdata[31:0];
          len_nxt     = in_len;
          gw_nxt      = in_tdata[69:38];
          port_nxt    = in_tdata[77:70];
          rep_nxt     = in_tdata[78];
          node_nxt    = '0;
          lvl_nxt     = '0;
          free_en_nxt = 1'b0;
          priority if (in_tuser == mtrl_pkg::OP_LOOKUP) begin
            cur_nxt   = default_r;
            state_nxt = S_LK_RD;
          end else if (in_tuser == mtrl_pkg::OP_ADD) begin
            // slot from the free list first, then from the untouched range
            priority if (head_r < KEY_W'(mtrl_pkg::ROUTE_SLOTS)) begin
              slot_req.fl_rd_en   = 1'b1;
              slot_req.fl_rd_addr = head_r[SLOT_W-1:0];
              state_nxt           = S_POP;
            end else if (used_r < KEY_W'(mtrl_pkg::ROUTE_SLOTS)) begin
              slot_nxt  = used_r[SLOT_W-1:0];
              used_nxt  = used_r + KEY_W'(1);
              state_nxt = S_ADD_WR;
            end else begin
              res_st_nxt  = mtrl_pkg::ST_FULL;
              res_key_nxt = '0;
              state_nxt   = S_RT_RD;
            end
          end else if (in_tuser == mtrl_pkg::OP_REMOVE) begin
            if (in_len == '0) begin
              cur_nxt     = default_r;
              default_nxt = '0;
              state_nxt   = S_FIN;
            end else begin
              state_nxt = S_WK;
            end
          end else begin
            res_st_nxt  = mtrl_pkg::ST_MISS;
            res_key_nxt = '0;
            state_nxt   = S_RT_RD;
          end
        end
      end

      S_LK_RD: begin
        key_req.rd_en   = 1'b1;
        key_req.rd_addr = mtrl_pkg::key_addr(node_r, leaf);
        link_req.rd_en   = 1'b1;
        link_req.rd_addr = mtrl_pkg::link_addr(node_r, idx);
        state_nxt        = S_LK_EV;
      end

      S_LK_EV: begin
        // deepest nonzero leaf key wins
        if (key_rdata != '0) cur_nxt = key_rdata;
        if (link_rdata == '0 || lvl_r == 3'd6) begin
          res_key_nxt = (key_rdata != '0) ? key_rdata : cur_r;
          res_st_nxt  = (key_rdata != '0 || cur_r != '0) ? mtrl_pkg::ST_OK
                                                         : mtrl_pkg::ST_MISS;
          state_nxt   = S_RT_RD;
        end else begin
          node_nxt  = link_rdata;
          lvl_nxt   = lvl_r + 3'd1;
          state_nxt = S_LK_RD;
        end
      end

      S_POP: begin
        slot_nxt  = head_r[SLOT_W-1:0];
        head_nxt  = free_rdata;
        state_nxt = S_ADD_WR;
      end

      S_ADD_WR: begin
        slot_req.rt_wr_en   = 1'b1;
        slot_req.rt_wr_addr = slot_r;
        slot_req.rt_wr_data = {port_r, gw_r};
        if (len_r != '0) begin
          state_nxt = S_WK;
        end else begin
          cur_nxt = default_r;
          if (default_r == '0 || rep_r) default_nxt = {1'b0, slot_r} + KEY_W'(1);
          state_nxt = S_FIN;
        end
      end

      S_WK: begin
        if (descend) begin
          link_req.rd_en   = 1'b1;
          link_req.rd_addr = mtrl_pkg::link_addr(node_r, idx);
          state_nxt        = S_WK_LINK;
        end else begin
          h_nxt           = leaf >> sh[2:0];
          key_req.rd_en   = 1'b1;
          key_req.rd_addr = mtrl_pkg::key_addr(node_r, leaf >> sh[2:0]);
          state_nxt       = S_H_RD;
        end
      end

      S_WK_LINK: begin
        priority if (link_rdata != '0) begin
          node_nxt  = link_rdata;
          lvl_nxt   = lvl_r + 3'd1;
          state_nxt = S_WK;
        end else if (op_r != mtrl_pkg::OP_ADD) begin
          // remove never grows the trie
          cur_nxt   = '0;
          state_nxt = S_FIN;
        end else if (nodes_used_r >= NODE_W'(mtrl_pkg::NODE_POOL)) begin
          free_en_nxt   = 1'b1;
          free_slot_nxt = slot_r;
          res_st_nxt    = mtrl_pkg::ST_FULL;
          res_key_nxt   = '0;
          state_nxt     = S_RT_RD;
        end else begin
          nodes_used_nxt   = new_node;
          link_req.wr_en   = 1'b1;
          link_req.wr_addr = mtrl_pkg::link_addr(node_r, idx);
          link_req.wr_data = new_node;
          node_nxt         = new_node;
          lvl_nxt          = lvl_r + 3'd1;
          state_nxt        = S_WK;
        end
      end

      S_H_RD: begin
        old_nxt         = key_rdata;
        key_req.rd_en   = 1'b1;
        key_req.rd_addr = mtrl_pkg::key_addr(node_r, h_r >> 1);
        state_nxt       = S_H_PAR;
      end

      S_H_PAR: begin
        cur_nxt = prev;
        nk_nxt  = nk;
        if (prev != nk && (prev == '0 || set_ok)) begin
          base_nxt  = {1'b0, h_r};
          w_nxt     = 10'd1;
          off_nxt   = '0;
          pend_nxt  = 1'b0;
          state_nxt = S_SW;
        end else begin
          state_nxt = S_FIN;
        end
      end

      S_SW: begin
        // entry read last cycle is rewritten if it still carries the old key
        if (pend_r && key_rdata == old_r) begin
          key_req.wr_en   = 1'b1;
          key_req.wr_addr = mtrl_pkg::key_addr(node_r, wx_r);
          key_req.wr_data = nk_r;
        end
        if (base_r < span) begin
          key_req.rd_en   = 1'b1;
          key_req.rd_addr = mtrl_pkg::key_addr(node_r, sw_x);
          wx_nxt          = sw_x;
          pend_nxt        = 1'b1;
          if (off_r + 10'd1 == w_r) begin
            base_nxt = base_r << 1;
            w_nxt    = w_r << 1;
            off_nxt  = '0;
          end else begin
            off_nxt = off_r + 10'd1;
          end
        end else begin
          pend_nxt  = 1'b0;
          state_nxt = S_FIN;
        end
      end

      S_FIN: begin
        if (op_r == mtrl_pkg::OP_ADD) begin
          if (cur_r != '0) begin
            res_st_nxt    = rep_r ? mtrl_pkg::ST_OK : mtrl_pkg::ST_EXISTS;
            res_key_nxt   = cur_r;
            free_en_nxt   = 1'b1;
            free_slot_nxt = rep_r ? SLOT_W'(cur_r - KEY_W'(1)) : slot_r;
          end else begin
            res_st_nxt  = mtrl_pkg::ST_OK;
            res_key_nxt = '0;
          end
        end else begin
          if (cur_r != '0) begin
            res_st_nxt    = mtrl_pkg::ST_OK;
            res_key_nxt   = cur_r;
            free_en_nxt   = 1'b1;
            free_slot_nxt = SLOT_W'(cur_r - KEY_W'(1));
          end else begin
            res_st_nxt  = mtrl_pkg::ST_MISS;
            res_key_nxt = '0;
          end
        end
        state_nxt = S_RT_RD;
      end

      S_RT_RD: begin
        slot_req.rt_rd_en   = 1'b1;
        slot_req.rt_rd_addr = SLOT_W'(res_key_r - KEY_W'(1));
        if (free_en_r) begin
          slot_req.fl_wr_en   = 1'b1;
          slot_req.fl_wr_addr = free_slot_r;
          slot_req.fl_wr_data = head_r;
          head_nxt            = {1'b0, free_slot_r};
        end
        state_nxt = S_OUT;
      end

      S_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_st_nxt    = res_st_r;
          out_had_nxt   = key_ok;
          out_gw_nxt    = key_ok ? route_rdata[31:0] : '0;
          out_port_nxt  = key_ok ? route_rdata[39:32] : '0;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      nodes_used_r <= '0;
      default_r    <= '0;
      head_r       <= KEY_W'(mtrl_pkg::ROUTE_SLOTS);
      used_r       <= '0;
      out_valid_r  <= 1'b0;
      pend_r       <= 1'b0;
      free_en_r    <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      nodes_used_r <= nodes_used_nxt;
      default_r    <= default_nxt;
      head_r       <= head_nxt;
      used_r       <= used_nxt;
      out_valid_r  <= out_valid_nxt;
      pend_r       <= pend_nxt;
      free_en_r    <= free_en_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    addr_r      <= addr_nxt;
    len_r       <= len_nxt;
    gw_r        <= gw_nxt;
    port_r      <= port_nxt;
    rep_r       <= rep_nxt;
    node_r      <= node_nxt;
    lvl_r       <= lvl_nxt;
    cur_r       <= cur_nxt;
    slot_r      <= slot_nxt;
    h_r         <= h_nxt;
    old_r       <= old_nxt;
    nk_r        <= nk_nxt;
    base_r      <= base_nxt;
    w_r         <= w_nxt;
    off_r       <= off_nxt;
    wx_r        <= wx_nxt;
    res_st_r    <= res_st_nxt;
    res_key_r   <= res_key_nxt;
    free_slot_r <= free_slot_nxt;
    out_st_r    <= out_st_nxt;
    out_had_r   <= out_had_nxt;
    out_gw_r    <= out_gw_nxt;
    out_port_r  <= out_port_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_port_r, out_gw_r};
  assign out_tuser  = {out_had_r, out_st_r};

  // a request is only taken by the idle sequencer
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> state_r == S_IDLE && !clr_busy)
    else $error("request taken outside idle");

  // a found route only comes with ok or exists
  a_had_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_had_r |-> out_st_r == mtrl_pkg::ST_OK || out_st_r == mtrl_pkg::ST_EXISTS)
    else $error("route reported with miss or full status");

  // pool and slot counters never pass their limits
  a_counters: assert property (@(posedge clk) disable iff (!rst_n)
    nodes_used_r <= NODE_W'(mtrl_pkg::NODE_POOL) && used_r <= KEY_W'(mtrl_pkg::ROUTE_SLOTS)
    && head_r <= KEY_W'(mtrl_pkg::ROUTE_SLOTS))
    else $error("node pool or slot counter overrun");

  // the subtree sweep ends only into the finish step
  a_sweep_exit: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SW |=> state_r == S_SW || state_r == S_FIN)
    else $error("sweep left to an unexpected state");

endmodule

@@ tb/multibit_trie_route_lookup_top_tb.sv @@
// testbench for the multibit trie route table: lookups, adds and removes checked against a trie model
`timescale 1ns / 1ps
module multibit_trie_route_lookup_top_tb;

  // watchdog covers the clearing pass after reset several times over
  localparam int STALL_LIMIT = 600000;

  // opcode with no meaning, answered as a miss
  localparam logic [1:0] OP_RESERVED = 2'd3;

  typedef struct {
    logic [1:0]  status;
    logic        had_route;
    logic [31:0] gateway;
    logic [7:0]  port;
  } route_result_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [79:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;
  logic [2:0]  out_tuser;

  multibit_trie_route_lookup_top i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // mirror of the trie; heap index 2..2n-1 holds both inner and leaf keys
  logic [mtrl_pkg::KEY_W-1:0]  root_keys [mtrl_pkg::ROOT_KEY_SPAN];
  logic [mtrl_pkg::KEY_W-1:0]  pool_keys [mtrl_pkg::NODE_POOL][mtrl_pkg::NODE_KEY_SPAN];
  logic [mtrl_pkg::NODE_W-1:0] root_links [mtrl_pkg::ROOT_FANOUT];
  logic [mtrl_pkg::NODE_W-1:0] pool_links [mtrl_pkg::NODE_POOL][mtrl_pkg::NODE_FANOUT];
  int unsigned       pool_used;
  int unsigned       default_key;
  logic [31:0]       slot_gateway [mtrl_pkg::ROUTE_SLOTS];
  logic [7:0]        slot_port [mtrl_pkg::ROUTE_SLOTS];
  int unsigned       slot_next [mtrl_pkg::ROUTE_SLOTS];
  int unsigned       free_head;
  int unsigned       slots_taken;

  route_result_t pending_results[$];
  logic [1:0]    last_status;
  int            mismatches;
  int            stall_cycles = 0;
  bit            no_idle;

  // prefixes known to the stimulus, used to aim lookups and removes
  logic [31:0] known_addr[$];
  logic [5:0]  known_len[$];

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int unsigned key_get(int unsigned node, int unsigned h);
    int unsigned n;
    n = node ? mtrl_pkg::NODE_FANOUT : mtrl_pkg::ROOT_FANOUT;
    if (h < 2) h = 2;
    if (h >= 2 * n) h = 2 * n - 1;
    return node ? pool_keys[node-1][h] : root_keys[h];
  endfunction

  function automatic void key_put(int unsigned node, int unsigned h, int unsigned k);
    if (node) pool_keys[node-1][h] = mtrl_pkg::KEY_W'(k);
    else      root_keys[h] = mtrl_pkg::KEY_W'(k);
  endfunction

  function automatic int unsigned link_get(int unsigned node, int unsigned i);
    return node ? pool_links[node-1][i & 15] : root_links[i & 255];
  endfunction

  function automatic void link_put(int unsigned node, int unsigned i, int unsigned v);
    if (node) pool_links[node-1][i & 15] = mtrl_pkg::NODE_W'(v);
    else      root_links[i & 255] = mtrl_pkg::NODE_W'(v);
  endfunction

  // walk to the level where the prefix ends and rewrite its expanded keys
  function automatic int unsigned prefix_update(logic [31:0] addr, logic [31:0] mask,
                                                int unsigned newkey, bit set, bit grow,
                                                ref bit full);
    int unsigned node, n, i, h, spread, old, prev, w, x, lk;
    int s;
    node = 0;
    n = mtrl_pkg::ROOT_FANOUT;
    s = 24;
    forever begin
      i = (addr >> s) & (n - 1);
      if (s >= 4 && (mask & ((32'd1 << s) - 32'd1)) != 0) begin
        lk = link_get(node, i);
        if (lk == 0) begin
          if (!grow) return 0;
          if (pool_used >= mtrl_pkg::NODE_POOL) begin
            full = 1'b1;
            return 0;
          end
          pool_used++;
          link_put(node, i, pool_used);
          lk = pool_used;
        end
        node = lk;
        s -= 4;
        n = mtrl_pkg::NODE_FANOUT;
      end else begin
        break;
      end
    end
    h = n + i;
    spread = n - ((mask >> s) & (n - 1));
    for (x = spread; x > 1; x /= 2) h /= 2;
    if (h < 2) h = 2;
    old = key_get(node, h);
    prev = old;
    if (prev != 0 && h > 3 && key_get(node, h / 2) == prev) prev = 0;
    if (newkey == 0 && h > 3) newkey = key_get(node, h / 2);
    if (prev != newkey && (prev == 0 || set)) begin
      w = 1;
      for (; h < 2 * n; h *= 2, w *= 2)
        for (x = h; x < h + w; x++)
          if (key_get(node, x) == old) key_put(node, x, newkey);
    end
    return prev;
  endfunction

  function automatic void slot_release(int unsigned slot);
    slot_next[slot] = free_head;
    free_head = slot;
  endfunction

  function automatic route_result_t route_answer(logic [1:0] st, int unsigned key);
    route_result_t r;
    r.status = st;
    r.had_route = key != 0;
    r.gateway = key ? slot_gateway[key-1] : '0;
    r.port = key ? slot_port[key-1] : '0;
    return r;
  endfunction

  // apply one request to the mirror and return the result it must produce
  function automatic route_result_t route_table_apply(logic [1:0] op, logic [31:0] addr,
                                                     logic [5:0] plen, logic [31:0] gw,
                                                     logic [7:0] port, bit rep);
    int unsigned len, cur, node, n, i, k, lk, slot, prev;
    int s;
    logic [31:0] mask;
    bit full;
    route_result_t r;
    full = 1'b0;
    len = (plen > 32) ? 32 : plen;
    mask = len ? (32'hFFFF_FFFF << (32 - len)) : 32'd0;
    case (op)
      mtrl_pkg::OP_LOOKUP: begin
        cur = default_key;
        node = 0;
        n = mtrl_pkg::ROOT_FANOUT;
        s = 24;
        forever begin
          i = (addr >> s) & (n - 1);
          k = key_get(node, n + i);
          if (k) cur = k;
          lk = link_get(node, i);
          if (lk == 0 || s < 4) break;
          node = lk;
          s -= 4;
          n = mtrl_pkg::NODE_FANOUT;
        end
        r = route_answer(cur ? mtrl_pkg::ST_OK : mtrl_pkg::ST_MISS, cur);
      end
      mtrl_pkg::OP_ADD: begin
        if (free_head < mtrl_pkg::ROUTE_SLOTS) begin
          slot = free_head;
          free_head = slot_next[slot];
        end else if (slots_taken < mtrl_pkg::ROUTE_SLOTS) begin
          slot = slots_taken;
          slots_taken++;
        end else begin
          return route_answer(mtrl_pkg::ST_FULL, 0);
        end
        slot_gateway[slot] = gw;
        slot_port[slot] = port;
        if (mask != 0) begin
          prev = prefix_update(addr, mask, slot + 1, rep, 1'b1, full);
          if (full) begin
            slot_release(slot);
            return route_answer(mtrl_pkg::ST_FULL, 0);
          end
        end else begin
          prev = default_key;
          if (prev == 0 || rep) default_key = slot + 1;
        end
        if (prev) begin
          r = route_answer(rep ? mtrl_pkg::ST_OK : mtrl_pkg::ST_EXISTS, prev);
          slot_release(rep ? prev - 1 : slot);
        end else begin
          r = route_answer(mtrl_pkg::ST_OK, 0);
        end
      end
      mtrl_pkg::OP_REMOVE: begin
        if (mask != 0) begin
          prev = prefix_update(addr, mask, 0, 1'b0, 1'b0, full);
          if (prev) void'(prefix_update(addr, mask, 0, 1'b1, 1'b0, full));
        end else begin
          prev = default_key;
          default_key = 0;
        end
        if (prev == 0) begin
          r = route_answer(mtrl_pkg::ST_MISS, 0);
        end else begin
          r = route_answer(mtrl_pkg::ST_OK, prev);
          slot_release(prev - 1);
        end
      end
      default: r = route_answer(mtrl_pkg::ST_MISS, 0);
    endcase
    return r;
  endfunction

  function automatic bit idle_now();
    return !no_idle && ($urandom_range(0, 99) < 22);
  endfunction

  // send one request beat; valid stays high into the next call unless a gap is taken
  task automatic send_request(logic [1:0] op, logic [31:0] addr, logic [5:0] plen,
                              logic [31:0] gw, logic [7:0] port, bit rep);
    route_result_t exp_r;
    @(negedge clk);
    while (idle_now()) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {1'b0, rep, port, gw, plen, addr};
    do @(posedge clk); while (!in_tready);
    exp_r = route_table_apply(op, addr, plen, gw, port, rep);
    last_status = exp_r.status;
    pending_results.insert(pending_results.size(), exp_r);
  endtask

  task automatic send_add(logic [31:0] addr, logic [5:0] plen, bit rep);
    int unsigned pick;
    send_request(mtrl_pkg::OP_ADD, addr, plen, $urandom, 8'($urandom), rep);
    if (known_addr.size() < 64) begin
      known_addr.insert(known_addr.size(), addr);
      known_len.insert(known_len.size(), plen);
    end else begin
      pick = $urandom_range(0, 63);
      known_addr[pick] = addr;
      known_len[pick] = plen;
    end
  endtask

  task automatic report_mismatch(string what, logic [39:0] got, logic [39:0] want);
    $display("mismatch in %s: got %h, expected %h at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  // result side: random back-pressure at the falling edge
  always @(negedge clk) begin
    out_tready <= !idle_now();
  end

  // check each result beat against the oldest expectation
  always @(posedge clk) begin
    route_result_t exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected beat", out_tdata, '0);
      end else begin
        exp_r = pending_results[0];
        pending_results.delete(0);
        if (out_tuser[1:0] !== exp_r.status)
          report_mismatch("status", 40'(out_tuser[1:0]), 40'(exp_r.status));
        if (out_tuser[2] !== exp_r.had_route)
          report_mismatch("had_route", 40'(out_tuser[2]), 40'(exp_r.had_route));
        if (out_tdata[31:0] !== exp_r.gateway)
          report_mismatch("result_gateway", 40'(out_tdata[31:0]), 40'(exp_r.gateway));
        if (out_tdata[39:32] !== exp_r.port)
          report_mismatch("result_port", 40'(out_tdata[39:32]), 40'(exp_r.port));
      end
    end
  end

  // watchdog on cycles with no beat on either side
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // extremes of every field, each opcode, default route, replace and saturation
  task automatic test_directed();
    send_request(mtrl_pkg::OP_LOOKUP, 32'h0000_0000, 6'd0, '0, '0, 1'b0);
    send_request(mtrl_pkg::OP_REMOVE, 32'h0A00_0000, 6'd8, '0, '0, 1'b0);
    send_request(mtrl_pkg::OP_REMOVE, 32'h0000_0000, 6'd0, '0, '0, 1'b0);
    send_request(mtrl_pkg::OP_ADD, 32'h0000_0000, 6'd0, 32'hFFFF_FFFF, 8'hFF, 1'b0);
    send_request(mtrl_pkg::OP_LOOKUP, 32'hFFFF_FFFF, 6'd0, '0, '0, 1'b0);
    send_request(mtrl_pkg::OP_ADD, 32'h1234_5678, 6'd0, 32'h0000_0001, 8'h01, 1'b0);
    send_request(mtrl_pkg::OP_ADD, 32'h0, 6'd0, 32'h0000_0002, 8'h02, 1'b1);
    send_request(mtrl_pkg::OP_ADD, 32'hFFFF_FFFF, 6'd32, 32'hA5A5_A5A5, 8'h5A, 1'b0);
    send_request(mtrl_pkg::OP_ADD, 32'hFFFF_FFFF, 6'd63, 32'h5A5A_5A5A, 8'hA5, 1'b0);
    send_request(mtrl_pkg::OP_ADD, 32'hFFFF_FFFF, 6'd40, 32'h1111_1111, 8'h11, 1'b1);
    send_request(mtrl_pkg::OP_LOOKUP, 32'hFFFF_FFFF, 6'd63, '0, '0, 1'b0);
    send_request(mtrl_pkg::OP_ADD, 32'h8000_0000, 6'd1, 32'h2222_2222, 8'h22, 1'b0);
    send_request(mtrl_pkg::OP_ADD, 32'hC0A8_0000, 6'd16, 32'h3333_3333, 8'h33, 1'b0);
    send_request(mtrl_pkg::OP_ADD, 32'hC0A8_0100, 6'd23, 32'h4444_4444, 8'h44, 1'b0);
    send_request(mtrl_pkg::OP_LOOKUP, 32'hC0A8_0101, 6'd0, '0, '0, 1'b0);
    send_request(mtrl_pkg::OP_LOOKUP, 32'hC0A9_0000, 6'd0, '0, '0, 1'b0);
    send_request(mtrl_pkg::OP_LOOKUP, 32'h7FFF_FFFF, 6'd0, '0, '0, 1'b0);
    send_request(mtrl_pkg::OP_REMOVE, 32'hC0A8_0100, 6'd23, '0, '0, 1'b0);
    send_request(mtrl_pkg::OP_LOOKUP, 32'hC0A8_0101, 6'd0, '0, '0, 1'b0);
    send_request(mtrl_pkg::OP_REMOVE, 32'hC0A8_0000, 6'd24, '0, '0, 1'b0);
    send_request(OP_RESERVED, 32'hFFFF_FFFF, 6'd63, 32'hFFFF_FFFF, 8'hFF, 1'b1);
    send_request(mtrl_pkg::OP_REMOVE, 32'h0, 6'd0, '0, '0, 1'b0);
    send_request(mtrl_pkg::OP_LOOKUP, 32'h0000_0001, 6'd0, '0, '0, 1'b0);
  endtask

  function automatic logic [5:0] pick_length();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 3) return 6'd0;
    if (r < 8) return 6'($urandom_range(33, 63));
    if (r < 18) return 6'($urandom_range(1, 8));
    return 6'($urandom_range(9, 32));
  endfunction

  // mostly adds and lookups around known prefixes, with removes and noise
  task automatic test_random_mix(int count);
    int unsigned r, j;
    logic [31:0] a;
    for (int n = 0; n < count; n++) begin
      if (n % 250 == 100) no_idle = 1'b1;
      if (n % 250 == 160) no_idle = 1'b0;
      r = $urandom_range(0, 99);
      j = known_addr.size() ? $urandom_range(0, known_addr.size() - 1) : 0;
      if (r < 38) begin
        a = $urandom;
        if (known_addr.size() && $urandom_range(0, 9) < 7)
          a = known_addr[j] ^ (a >> ((known_len[j] > 32) ? 32 : known_len[j]));
        send_request(mtrl_pkg::OP_LOOKUP, a, 6'($urandom), $urandom, 8'($urandom),
                     1'($urandom));
      end else if (r < 78) begin
        if (known_addr.size() && $urandom_range(0, 2) == 0)
          send_add(known_addr[j], known_len[j], 1'($urandom));
        else
          send_add($urandom, pick_length(), 1'($urandom));
      end else if (r < 95) begin
        if (known_addr.size() && $urandom_range(0, 4) != 0)
          send_request(mtrl_pkg::OP_REMOVE, known_addr[j], known_len[j], $urandom,
                       8'($urandom), 1'($urandom));
        else
          send_request(mtrl_pkg::OP_REMOVE, $urandom, pick_length(), $urandom, 8'($urandom),
                       1'b0);
      end else begin
        send_request(OP_RESERVED, $urandom, 6'($urandom), $urandom, 8'($urandom),
                     1'($urandom));
      end
    end
  endtask

  // exhaust the node pool with host routes, then the slots with root prefixes, then remove and re-add hosts
  task automatic test_table_full();
    int full_seen;
    logic [31:0] hosts[$];
    logic [31:0] a;
    full_seen = 0;
    for (int n = 0; n < 2000 && full_seen < 3; n++) begin
      a = $urandom;
      send_request(mtrl_pkg::OP_ADD, a, 6'd32, $urandom, 8'($urandom), 1'b0);
      if (last_status == mtrl_pkg::ST_FULL) full_seen++;
      else hosts.insert(hosts.size(), a);
    end
    full_seen = 0;
    for (int n = 0; n < 3000 && full_seen < 3; n++) begin
      send_request(mtrl_pkg::OP_ADD, $urandom, 6'($urandom_range(1, 8)), $urandom,
                   8'($urandom), 1'($urandom));
      if (last_status == mtrl_pkg::ST_FULL && slots_taken == mtrl_pkg::ROUTE_SLOTS
          && free_head == mtrl_pkg::ROUTE_SLOTS)
        full_seen++;
    end
    for (int n = 0; n < 40 && n < hosts.size(); n++) begin
      send_request(mtrl_pkg::OP_REMOVE, hosts[n], 6'd32, '0, '0, 1'b0);
      send_request(mtrl_pkg::OP_LOOKUP, hosts[n], 6'd0, '0, '0, 1'b0);
    end
    for (int n = 0; n < 20 && n < hosts.size(); n++)
      send_request(mtrl_pkg::OP_ADD, hosts[n], 6'd32, $urandom, 8'($urandom), 1'b0);
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    mismatches = 0;
    no_idle = 1'b0;
    for (int i = 0; i < mtrl_pkg::ROOT_KEY_SPAN; i++) root_keys[i] = '0;
    for (int i = 0; i < mtrl_pkg::ROOT_FANOUT; i++) root_links[i] = '0;
    for (int p = 0; p < mtrl_pkg::NODE_POOL; p++) begin
      for (int i = 0; i < mtrl_pkg::NODE_KEY_SPAN; i++) pool_keys[p][i] = '0;
      for (int i = 0; i < mtrl_pkg::NODE_FANOUT; i++) pool_links[p][i] = '0;
    end
    pool_used = 0;
    default_key = 0;
    free_head = mtrl_pkg::ROUTE_SLOTS;
    slots_taken = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_random_mix(200);
    test_table_full();

    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (600) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/mtrl_pkg.sv
rtl/core/mtrl_trie_mem.sv
rtl/core/mtrl_slot_mem.sv
rtl/core/multibit_trie_route_lookup_top.sv
tb/multibit_trie_route_lookup_top_tb.sv
